/* hdl/matrix_multiply_add_sub_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply/add/sub core
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ADD_SUB_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_ADD_SUB_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMAS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MMAS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mmas_pkg.sv */
// ----------------------------------------------------------------------------
// mmas_pkg
// Shared constants and types of the matrix multiply/add/sub core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmas_pkg;

    localparam int MAX_DIM_DEF = 8;     // largest matrix dimension
    localparam int ELEM_W      = 32;    // Q16.16 element
    localparam int RC_W        = 3;     // row/col field width
    localparam int RND_W       = 48;    // one rounded product, Q32.16
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [MODE_W-1:0] MODE_MUL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd2;
    localparam int MODE_SUB_BIT = 1;    // bit 1 set selects subtract

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

    // control that travels alongside the operands through the MAC
    typedef struct packed {
        logic valid;
        logic first;    // first term of a result element
        logic last;     // last term of a result element
        logic mul;      // multiply, else add/sub
        logic sub;
    } mac_ctrl_t;

    // finished element from the MAC
    typedef struct packed {
        logic              done;
        logic              sat;
        logic [ELEM_W-1:0] value;
    } mac_res_t;

endpackage

/* hdl/mmas_store.sv */
// ----------------------------------------------------------------------------
// mmas_store
// One-port-write, one-port-read synchronous element memory with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmas_store #(
    parameter  int DEPTH  = mmas_pkg::MAX_DIM_DEF * mmas_pkg::MAX_DIM_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [mmas_pkg::ELEM_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [mmas_pkg::ELEM_W-1:0] rd_data
);

    logic [mmas_pkg::ELEM_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/mmas_mac.sv */
// ----------------------------------------------------------------------------
// mmas_mac
// Multiply, round, accumulate and saturate pipeline (add/sub shares it).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmas_mac #(
    parameter int MAX_DIM = mmas_pkg::MAX_DIM_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mmas_pkg::mac_ctrl_t         ctrl_in,    // aligned with a_data/b_data
    input  logic [mmas_pkg::ELEM_W-1:0] a_data,
    input  logic [mmas_pkg::ELEM_W-1:0] b_data,
    output mmas_pkg::mac_res_t          res
);

    localparam int ELEM_W = mmas_pkg::ELEM_W;
    localparam int RND_W  = mmas_pkg::RND_W;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SUM_W  = ELEM_W + 1;
    localparam int ACC_W  = RND_W + $clog2(MAX_DIM);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(64'shFFFF_FFFF_8000_0000);
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(64'sd32768);

    mmas_pkg::mac_ctrl_t c1_reg, c2_reg, c3_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [RND_W-1:0]  rnd_reg;
    logic signed [RND_W-1:0]  rnd_next;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ELEM_W-1:0] a_s, b_s;

    assign a_s = signed'(a_data);
    assign b_s = signed'(b_data);

    // stage 1: product and sum
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a_s) * PROD_W'(b_s);
        sum_reg  <= ctrl_in.sub ? (SUM_W'(a_s) - SUM_W'(b_s))
                                : (SUM_W'(a_s) + SUM_W'(b_s));
    end

    // stage 2: round to nearest, ties up (floor of p + 2^15)
    always_comb begin
        prod_rnd = prod_reg + HALF_LSB;
        rnd_next = c1_reg.mul ? signed'(prod_rnd[PROD_W-1:16]) : RND_W'(sum_reg);
    end

    always_ff @(posedge aclk) begin
        rnd_reg <= rnd_next;
    end

    // stage 3: exact accumulation
    assign acc_next = c2_reg.first ? ACC_W'(rnd_reg) : (acc_reg + ACC_W'(rnd_reg));

    always_ff @(posedge aclk) begin
        if (c2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end else begin
            c1_reg <= ctrl_in;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    always_comb begin
        res.done = c3_reg.valid && c3_reg.last;
        if (acc_reg > SAT_HI) begin
            res.sat   = 1'b1;
            res.value = ELEM_W'(SAT_HI);
        end else if (acc_reg < SAT_LO) begin
            res.sat   = 1'b1;
            res.value = ELEM_W'(SAT_LO);
        end else begin
            res.sat   = 1'b0;
            res.value = acc_reg[ELEM_W-1:0];
        end
    end

endmodule

/* hdl/matrix_multiply_add_sub_core.sv */
// Loading takes one element per cycle while s_tvalid is high (s_tready high
// while loading). After the final element, results are produced one at a time
// through the one shared MAC and its single read port per store, and each can
// be stalled by m_tready. No element is taken while C is being produced. Reset
// (aresetn low, synchronous) clears the load count, the state and the pipeline;
// registers return to mode 0, 4 x 4 x 4.
// ----------------------------------------------------------------------------
// matrix_multiply_add_sub_core
// Loads A then B into two element memories, then streams out C = A*B, A+B
// or A-B in Q16.16 with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix_multiply_add_sub_core_macros.svh"

module matrix_multiply_add_sub_core #(
    parameter int MAX_DIM = mmas_pkg::MAX_DIM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mmas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mmas_pkg::CFG_DATA_W-1:0] cfg_data,
    // input elements
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,    // [31:0] element
    // result elements
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,    // [31:0] value, [34:32] row,
                                                        // [37:35] col, [39:38] zero
    output logic                            m_tuser,    // [0] saturated
    output logic                            m_tlast
);

    localparam int ELEM_W   = mmas_pkg::ELEM_W;
    localparam int RC_W     = mmas_pkg::RC_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int PROD_W   = 2 * DIM_W;
    localparam int TOT_W    = PROD_W + 1;
    localparam int CNT_W    = $clog2(2 * DEPTH);
    localparam int M_DATA_W = 40;
    localparam logic [4:0] MAX_DIM5 = 5'(MAX_DIM);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,     // taking elements of A and B
        ST_ISSUE = 4'b0010,     // reading operand pairs for one C element
        ST_WAIT  = 4'b0100,     // MAC pipeline draining
        ST_OUT   = 4'b1000      // result waiting on m_tready
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [mmas_pkg::MODE_W-1:0] mode_reg;
    logic [3:0]                  a_rows_reg, inner_reg, b_cols_reg;

    // load side
    logic [CNT_W-1:0]  load_cnt_reg;
    logic [DIM_W-1:0]  rows_c, mid_c, cols_c;
    logic              mul_c, sub_c;
    logic [PROD_W-1:0] na, nb;
    logic [TOT_W-1:0]  total, pos_ext, pos_p1;
    logic              in_acc, store_more, in_left;
    logic              left_we, right_we;
    logic [ADDR_W-1:0] left_waddr, right_waddr;

    // compute side: sizes frozen at the final element
    logic [DIM_W-1:0]  rows_reg, mid_reg, cols_reg;
    logic              mul_reg, sub_reg;
    logic [IDX_W-1:0]  i_reg, j_reg, k_reg;
    logic [ADDR_W-1:0] a_base_reg, a_addr_reg, b_addr_reg;
    logic              i_last, j_last, k_last;
    logic              issue;

    mmas_pkg::mac_ctrl_t issue_ctrl, ctrl_d_reg;
    mmas_pkg::mac_res_t  mac_res;
    logic [ELEM_W-1:0]   left_rdata, right_rdata;

    // output register
    logic [ELEM_W-1:0] value_reg;
    logic [RC_W-1:0]   row_reg, col_reg;
    logic              sat_reg, last_reg;
    logic              out_acc;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] v);
        logic [DIM_W-1:0] r;
        if (v == 4'd0) begin
            r = DIM_W'(1);
        end else if ({1'b0, v} > MAX_DIM5) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // configuration: always ready, unenforced; the user must write it only between matrices
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= mmas_pkg::MODE_MUL;
            a_rows_reg <= 4'd4;
            inner_reg  <= 4'd4;
            b_cols_reg <= 4'd4;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mmas_pkg::REG_MODE:   mode_reg   <= cfg_data[mmas_pkg::MODE_W-1:0];
                mmas_pkg::REG_A_ROWS: a_rows_reg <= cfg_data;
                mmas_pkg::REG_INNER:  inner_reg  <= cfg_data;
                mmas_pkg::REG_B_COLS: b_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // load: sizes are taken from the registers on every item, so a
    // register change mid-load moves the final-element point
    // ------------------------------------------------------------------
    always_comb begin
        rows_c = clamp_dim(a_rows_reg);
        mid_c  = clamp_dim(inner_reg);
        cols_c = clamp_dim(b_cols_reg);
        // mode 3 has bit 1 set and so subtracts
        sub_c  = mode_reg[mmas_pkg::MODE_SUB_BIT];
        mul_c  = (mode_reg == mmas_pkg::MODE_MUL);
        na     = mul_c ? PROD_W'(rows_c) * PROD_W'(mid_c) : PROD_W'(rows_c) * PROD_W'(cols_c);
        nb     = mul_c ? PROD_W'(mid_c) * PROD_W'(cols_c) : PROD_W'(rows_c) * PROD_W'(cols_c);
        total  = TOT_W'(na) + TOT_W'(nb);
        pos_ext = TOT_W'(load_cnt_reg);
        pos_p1  = pos_ext + TOT_W'(1);
    end

    assign s_tready   = (state_reg == ST_LOAD);
    assign in_acc     = s_tvalid && s_tready;
    assign store_more = (pos_p1 < total);
    assign in_left    = (pos_ext < TOT_W'(na));
    // past the end (registers shrank mid-load): element dropped, C still emitted
    assign left_we    = in_acc && store_more && in_left;
    assign right_we   = in_acc && (pos_p1 <= total) && !in_left;
    assign left_waddr  = ADDR_W'(pos_ext);
    assign right_waddr = ADDR_W'(pos_ext - TOT_W'(na));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg <= '0;
        end else if (in_acc) begin
            load_cnt_reg <= store_more ? CNT_W'(pos_p1) : '0;
        end
    end

    // ------------------------------------------------------------------
    // element memories; the final B element is written in the cycle before
    // the first read, so no forwarding is needed
    // ------------------------------------------------------------------
    mmas_store #(.DEPTH(DEPTH)) u_left (
        .aclk    (aclk),
        .wr_en   (left_we),
        .wr_addr (left_waddr),
        .wr_data (s_tdata),
        .rd_en   (issue),
        .rd_addr (a_addr_reg),
        .rd_data (left_rdata)
    );

    mmas_store #(.DEPTH(DEPTH)) u_right (
        .aclk    (aclk),
        .wr_en   (right_we),
        .wr_addr (right_waddr),
        .wr_data (s_tdata),
        .rd_en   (issue),
        .rd_addr (b_addr_reg),
        .rd_data (right_rdata)
    );

    // ------------------------------------------------------------------
    // sequencer: one operand pair per cycle per C element, then drain
    // ------------------------------------------------------------------
    assign issue  = (state_reg == ST_ISSUE);
    assign k_last = (DIM_W'(k_reg) + DIM_W'(1)) == mid_reg;
    assign j_last = (DIM_W'(j_reg) + DIM_W'(1)) == cols_reg;
    assign i_last = (DIM_W'(i_reg) + DIM_W'(1)) == rows_reg;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        issue_ctrl.valid = issue;
        issue_ctrl.first = (k_reg == '0);
        issue_ctrl.last  = k_last;
        issue_ctrl.mul   = mul_reg;
        issue_ctrl.sub   = sub_reg;
    end

    // read data arrives in the cycle after the address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_d_reg <= '0;
        end else begin
            ctrl_d_reg <= issue_ctrl;
        end
    end

    mmas_mac #(.MAX_DIM(MAX_DIM)) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_in (ctrl_d_reg),
        .a_data  (left_rdata),
        .b_data  (right_rdata),
        .res     (mac_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (in_acc && !store_more) begin
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (k_last) begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (mac_res.done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        state_reg <= last_reg ? ST_LOAD : ST_ISSUE;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // loop indices and read addresses
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            if (in_acc && !store_more) begin
                rows_reg   <= rows_c;
                cols_reg   <= cols_c;
                mid_reg    <= mul_c ? mid_c : DIM_W'(1);
                mul_reg    <= mul_c;
                sub_reg    <= sub_c;
                i_reg      <= '0;
                j_reg      <= '0;
                k_reg      <= '0;
                a_base_reg <= '0;
                a_addr_reg <= '0;
                b_addr_reg <= '0;
            end
        end else if (issue && !k_last) begin
            // next term: along the row of A, down the column of B
            k_reg      <= k_reg + IDX_W'(1);
            a_addr_reg <= a_addr_reg + ADDR_W'(1);
            b_addr_reg <= b_addr_reg + ADDR_W'(cols_reg);
        end else if (out_acc && !last_reg) begin
            k_reg <= '0;
            if (j_last) begin
                j_reg <= '0;
                i_reg <= i_reg + IDX_W'(1);
            end else begin
                j_reg <= j_reg + IDX_W'(1);
            end
            if (!mul_reg) begin
                // element-wise: both stores walk in step
                a_addr_reg <= a_addr_reg + ADDR_W'(1);
                b_addr_reg <= b_addr_reg + ADDR_W'(1);
            end else if (j_last) begin
                a_base_reg <= a_base_reg + ADDR_W'(mid_reg);
                a_addr_reg <= a_base_reg + ADDR_W'(mid_reg);
                b_addr_reg <= '0;
            end else begin
                a_addr_reg <= a_base_reg;
                b_addr_reg <= ADDR_W'(j_reg) + ADDR_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WAIT && mac_res.done) begin
            value_reg <= mac_res.value;
            sat_reg   <= mac_res.sat;
            row_reg   <= RC_W'(i_reg);
            col_reg   <= RC_W'(j_reg);
            last_reg  <= i_last && j_last;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {{(M_DATA_W - ELEM_W - 2 * RC_W){1'b0}}, col_reg, row_reg, value_reg};
    assign m_tuser  = sat_reg;
    assign m_tlast  = last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `MMAS_ASSERT_IMPL(a_load_out_excl, aclk, aresetn, s_tready, !m_tvalid, "load and output overlap")
    `MMAS_ASSERT_IMPL(a_done_in_wait, aclk, aresetn, mac_res.done, state_reg == ST_WAIT, "MAC result outside drain")
    `MMAS_ASSERT_IMPL(a_cnt_idle, aclk, aresetn, state_reg != ST_LOAD, load_cnt_reg == '0, "load count not cleared")
    `MMAS_ASSERT_NEXT(a_last_reload, aclk, aresetn, out_acc && m_tlast, s_tready, "no reload after last item")

endmodule
